@@ hw/rtl/dgs_pkg.sv @@
// Types and constants shared by the dense Gauss-Seidel solver.
`timescale 1ns / 1ps
package dgs_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_LOAD_X = 2'd2,
    MODE_SOLVE  = 2'd3
  } mode_e;

  localparam logic [1:0] CFG_SIZE      = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIVD_W = 63;

  localparam logic [6:0]  SIZE_RESET = 7'd64;
  localparam logic [31:0] TOL_RESET  = 32'd66;
  localparam logic [15:0] ITER_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         index;
    logic signed [31:0] solution_value;
    logic [15:0]        sweeps_done;
    logic               converged;
    logic               zero_pivot;
    logic               last;
  } out_item_t;

endpackage

@@ hw/rtl/dgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/dgs_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dgs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dgs_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [dgs_pkg::DATA_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [dgs_pkg::DIVD_W-1:0]   quotient_o
);

  localparam int unsigned CW = $clog2(dgs_pkg::DIVD_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [dgs_pkg::DATA_W-1:0]  div_q;
  logic [dgs_pkg::DATA_W-1:0]  rem_q, rem_d;
  logic [dgs_pkg::DIVD_W-1:0]  quo_q, quo_d;
  logic [dgs_pkg::DATA_W:0]    rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, quo_q[dgs_pkg::DIVD_W-1]};
    trial  = rem_sh - {1'b0, div_q};
    if (!trial[dgs_pkg::DATA_W]) begin
      rem_d = trial[dgs_pkg::DATA_W-1:0];
      quo_d = {quo_q[dgs_pkg::DIVD_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[dgs_pkg::DATA_W-1:0];
      quo_d = {quo_q[dgs_pkg::DIVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(dgs_pkg::DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hw/rtl/dense_gauss_seidel_solver_top.sv @@
// Top level of the dense Gauss-Seidel solver: loads, sweep sequencer, result stream.
// Load items are taken only while the solver is idle; configuration writes are always accepted.
// A solve item checks the pivots, then, unless one is zero, runs sweeps in which each
// row does a multiply-accumulate per column on the shared multiplier (read, multiply,
// accumulate) and one division, then result reads that wait on any output stall.
// After reset a clearing pass over all MAX_SIZE*MAX_SIZE entries zeroes the memories;
// no item is taken meanwhile.
`timescale 1ns / 1ps
module dense_gauss_seidel_solver_top #(
  parameter int unsigned MAX_SIZE  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dgs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dgs_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_SIZE);
  localparam int unsigned NW = $clog2(MAX_SIZE + 1);
  localparam int unsigned MD = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW = $clog2(MD);
  localparam logic signed [63:0] NUM_LIM = (64'sd1 <<< (62 - FRAC_BITS)) - 64'sd1;

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_P_RD  = 12'b0000_0000_0100,
    ST_P_CK  = 12'b0000_0000_1000,
    ST_S_RD  = 12'b0000_0001_0000,
    ST_S_MUL = 12'b0000_0010_0000,
    ST_S_ACC = 12'b0000_0100_0000,
    ST_S_NUM = 12'b0000_1000_0000,
    ST_S_DIV = 12'b0001_0000_0000,
    ST_S_WB  = 12'b0010_0000_0000,
    ST_O_RD  = 12'b0100_0000_0000,
    ST_O_LD  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]  size_q;
  logic [31:0] tol_q;
  logic [15:0] iter_q;

  logic [AW-1:0] clr_q, clr_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [NW-1:0] n_q, n_d;
  logic [15:0]   lim_q, lim_d, cnt_q, cnt_d;
  logic          bad_q, bad_d, done_q, done_d, small_q, small_d;
  logic signed [63:0] acc_q, acc_d, prod_q, prod_d;
  logic signed [31:0] piv_q, piv_d, xold_q, xold_d;
  logic          out_valid_q, out_valid_d;
  dgs_pkg::out_item_t out_q, out_d;

  logic          a_we, b_we, x_we;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [IW-1:0] b_waddr, x_waddr, x_raddr;
  logic [31:0]   a_wdata, b_wdata, x_wdata;
  logic signed [31:0] a_rdata, b_rdata, x_rdata;

  logic          div_start, div_done;
  logic [dgs_pkg::DIVD_W-1:0] div_dividend, div_quo;
  logic [31:0]   div_divisor;
  logic          q_neg_q, q_neg_d;

  logic          in_fire, out_fire, last_i, last_j, row_ok, col_ok;
  logic signed [63:0] num_raw, num_cl, num_mag;
  logic signed [31:0] nx;
  logic signed [32:0] diff;
  logic [32:0]   diff_mag;
  logic [6:0]    size_cl;

  dgs_ram #(.WIDTH(32), .DEPTH(MD)) u_a_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  dgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_b_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(i_q), .rdata_o(b_rdata)
  );
  dgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x_ram (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .raddr_i(x_raddr), .rdata_o(x_rdata)
  );

  dgs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .done_o(div_done), .quotient_o(div_quo)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign last_i = (NW'(i_q) == n_q - 1'b1);
  assign last_j = (NW'(j_q) == n_q - 1'b1);
  assign row_ok = (int'(in_item_i.row) < MAX_SIZE);
  assign col_ok = (int'(in_item_i.col) < MAX_SIZE);

  assign a_raddr = AW'(int'(i_q) * MAX_SIZE + int'((state_q == ST_P_RD) ? i_q : j_q));
  assign x_raddr = (state_q == ST_O_RD || state_q == ST_O_LD) ? i_q : j_q;
  assign prod_d  = a_rdata * x_rdata;

  always_comb begin
    size_cl  = (size_q == 7'd0) ? 7'd1 : size_q;
    num_raw  = 64'(b_rdata) - acc_q;
    if (num_raw > NUM_LIM) begin
      num_cl = NUM_LIM;
    end else if (num_raw < -NUM_LIM) begin
      num_cl = -NUM_LIM;
    end else begin
      num_cl = num_raw;
    end
    num_mag      = num_cl[63] ? -num_cl : num_cl;
    div_dividend = dgs_pkg::DIVD_W'(num_mag <<< FRAC_BITS);
    div_divisor  = piv_q[31] ? 32'(-piv_q) : 32'(piv_q);
    if (q_neg_q) begin
      nx = (div_quo > dgs_pkg::DIVD_W'(64'h8000_0000)) ? 32'sh8000_0000 : -32'(div_quo);
    end else begin
      nx = (div_quo > dgs_pkg::DIVD_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(div_quo);
    end
    diff     = 33'(xold_q) - 33'(nx);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    lim_d       = lim_q;
    cnt_d       = cnt_q;
    bad_d       = bad_q;
    done_d      = done_q;
    small_d     = small_q;
    acc_d       = acc_q;
    piv_d       = piv_q;
    xold_d      = xold_q;
    q_neg_d     = q_neg_q;
    out_valid_d = out_valid_q && !out_fire;
    out_d       = out_q;
    div_start   = 1'b0;
    a_we        = 1'b0;
    b_we        = 1'b0;
    x_we        = 1'b0;
    a_waddr     = AW'(int'(in_item_i.row) * MAX_SIZE + int'(in_item_i.col));
    b_waddr     = IW'(in_item_i.row);
    x_waddr     = IW'(in_item_i.row);
    a_wdata     = in_item_i.entry_value;
    b_wdata     = in_item_i.entry_value;
    x_wdata     = in_item_i.entry_value;
    case (state_q)
      ST_CLEAR: begin
        a_we    = 1'b1;
        b_we    = 1'b1;
        x_we    = 1'b1;
        a_waddr = clr_q;
        b_waddr = IW'(clr_q);
        x_waddr = IW'(clr_q);
        a_wdata = '0;
        b_wdata = '0;
        x_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(MD - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.mode)
            dgs_pkg::MODE_LOAD_A: a_we = row_ok && col_ok;
            dgs_pkg::MODE_LOAD_B: b_we = row_ok;
            dgs_pkg::MODE_LOAD_X: x_we = row_ok;
            dgs_pkg::MODE_SOLVE: begin
              n_d     = (int'(size_cl) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_cl);
              lim_d   = (iter_q == 16'd0) ? 16'd1 : iter_q;
              cnt_d   = '0;
              bad_d   = 1'b0;
              done_d  = 1'b0;
              i_d     = '0;
              state_d = ST_P_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_P_RD: state_d = ST_P_CK;
      ST_P_CK: begin
        if (a_rdata == 32'sd0) begin
          bad_d = 1'b1;
        end
        if (last_i) begin
          i_d = '0;
          if (bad_d) begin
            state_d = ST_O_RD;
          end else begin
            j_d     = '0;
            acc_d   = '0;
            small_d = 1'b1;
            state_d = ST_S_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_P_RD;
        end
      end
      ST_S_RD: state_d = ST_S_MUL;
      ST_S_MUL: begin
        if (j_q == i_q) begin
          piv_d  = a_rdata;
          xold_d = x_rdata;
        end
        state_d = ST_S_ACC;
      end
      ST_S_ACC: begin
        if (j_q != i_q) begin
          acc_d = acc_q + (prod_q >>> FRAC_BITS);
        end
        if (last_j) begin
          state_d = ST_S_NUM;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_S_NUM: begin
        div_start = 1'b1;
        q_neg_d   = num_cl[63] ^ piv_q[31];
        state_d   = ST_S_DIV;
      end
      ST_S_DIV: begin
        if (div_done) begin
          state_d = ST_S_WB;
        end
      end
      ST_S_WB: begin
        x_we    = 1'b1;
        x_waddr = i_q;
        x_wdata = nx;
        if (!(diff_mag < {1'b0, tol_q})) begin
          small_d = 1'b0;
        end
        j_d   = '0;
        acc_d = '0;
        if (last_i) begin
          i_d   = '0;
          cnt_d = cnt_q + 1'b1;
          if (small_d) begin
            done_d  = 1'b1;
            state_d = ST_O_RD;
          end else if (cnt_d >= lim_q) begin
            state_d = ST_O_RD;
          end else begin
            small_d = 1'b1;
            state_d = ST_S_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_O_RD: state_d = ST_O_LD;
      ST_O_LD: begin
        if (!out_valid_q || out_fire) begin
          out_valid_d          = 1'b1;
          out_d.index          = 6'(i_q);
          out_d.solution_value = x_rdata;
          out_d.sweeps_done    = cnt_q;
          out_d.converged      = done_q;
          out_d.zero_pivot     = bad_q;
          out_d.last           = last_i;
          if (last_i) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_O_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      lim_q       <= '0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      done_q      <= 1'b0;
      small_q     <= 1'b0;
      out_valid_q <= 1'b0;
      size_q      <= dgs_pkg::SIZE_RESET;
      tol_q       <= dgs_pkg::TOL_RESET;
      iter_q      <= dgs_pkg::ITER_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      lim_q       <= lim_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      done_q      <= done_d;
      small_q     <= small_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          dgs_pkg::CFG_SIZE:      size_q <= cfg_data_i[6:0];
          dgs_pkg::CFG_TOLERANCE: tol_q  <= cfg_data_i;
          dgs_pkg::CFG_MAX_ITER:  iter_q <= cfg_data_i[15:0];
          default:                size_q <= size_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    piv_q   <= piv_d;
    xold_q  <= xold_d;
    q_neg_q <= q_neg_d;
    out_q   <= out_d;
  end

  a_wb_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_WB) |-> $past(div_done))
    else $error("estimate written without a finished division");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_O_LD))
    else $error("result raised outside the result load step");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.converged && out_q.zero_pivot))
    else $error("converged and zero pivot both set");

  a_sweeps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.zero_pivot) |-> (out_q.sweeps_done != 16'd0))
    else $error("result without any sweep");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_DIV) |-> in_stall_o)
    else $error("input taken during a sweep");

endmodule
